>>> src/matrix3_inverse_defines.svh
// Assertion helpers for the file that checks the inverse pipeline.
`ifndef MATRIX3_INVERSE_DEFINES_SVH
`define MATRIX3_INVERSE_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define M3I_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define M3I_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/m3i_pkg.sv
`default_nettype none
package m3i_pkg;

  localparam int W   = 32;            // word width
  localparam int F   = 16;            // fractional bits
  localparam int PW  = 2 * W;         // entry product
  localparam int CW  = 2 * W + 1;     // cofactor
  localparam int HW  = W + 1;         // cofactor half for the determinant
  localparam int LPW = 2 * W + 1;     // determinant partial product
  localparam int DW  = 3 * W + 3;     // determinant
  localparam int NW  = CW + 2 * F;    // dividend magnitude
  localparam int SW  = DW + W;        // shifted divisor
  localparam int XW  = (NW > SW) ? NW : SW;
  localparam int QW  = W + 1;         // quotient magnitude with overflow bit
  localparam int IN_TDATA_W  = ((9 * W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((10 * W + 7) / 8) * 8;

  localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

  typedef logic [W-1:0] word_t;
  typedef logic [2:0][2:0][W-1:0] mat_t;
  typedef logic signed [PW-1:0] prod_t;
  typedef logic signed [CW-1:0] cof_t;
  typedef logic [CW-1:0] cmag_t;
  typedef logic signed [LPW-1:0] pp_t;
  typedef logic signed [DW-1:0] det_t;
  typedef logic [DW-1:0] dmag_t;
  typedef logic [NW-1:0] num_t;
  typedef logic [SW-1:0] ds_t;
  typedef logic [XW-1:0] xw_t;
  typedef logic [QW-1:0] quo_t;
  typedef logic [IN_TDATA_W-1:0] in_data_t;
  typedef logic [OUT_TDATA_W-1:0] out_data_t;

  typedef struct packed {
    logic [2:0][2:0][CW-1:0] cof;
    logic [2:0][W-1:0]       row0;
  } cof_bus_t;

  typedef struct packed {
    logic [NW-1:0] r;
    logic [QW-1:0] q;
    logic          neg;
  } lane_t;

  typedef struct packed {
    lane_t [8:0]   lane;
    logic [SW-1:0] ds;
    logic          zero;
    logic [W-1:0]  det_value;
    logic          det_ovf;
  } div_t;

endpackage
`default_nettype wire

>>> src/matrix3_inverse.sv
// 3x3 matrix inverse by the adjugate method, signed Q16.16 in and out.
// Throughput: one matrix per cycle while out_tready is high. Stages from an
// accepted input to its result: 2 cofactor, 4 determinant, 33 divider steps, 1 output register.
// Every stage stalls on its own, so bubbles close up.
// Reset (rst_n low, synchronous) clears all stage valid bits; data registers keep their contents.
`default_nettype none
`include "matrix3_inverse_defines.svh"
module matrix3_inverse (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // Input matrix, from the lowest bit up: in_r1c1, in_r1c2, in_r1c3, in_r2c1,
  // in_r2c2, in_r2c3, in_r3c1, in_r3c2, in_r3c3, one word each.
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [m3i_pkg::IN_TDATA_W-1:0]  in_tdata,
  // Result, from the lowest bit up: inv_r1c1 .. inv_r3c3, det_value.
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [m3i_pkg::OUT_TDATA_W-1:0]      out_tdata,
  // Result flags, from the lowest bit up: singular, overflow.
  output logic [1:0]                           out_tuser
);

  // Stage map. The cofactor block forms the eighteen entry products and
  // then the nine cofactors exactly. The determinant block expands along
  // the first row, splitting each cofactor so the multipliers stay about
  // one word wide, and then sets up nine unsigned divisions that share the
  // magnitude of the determinant as divisor. Each divider step resolves
  // one quotient bit for every lane; the first step resolves a guard bit
  // that flags quotients too large for a word. The output stage applies
  // signs, saturates, and zeroes everything for a singular matrix.

  m3i_pkg::mat_t     mat;
  m3i_pkg::cof_bus_t cof_bus;
  logic              cof_valid, cof_ready;
  m3i_pkg::div_t     div_bus [m3i_pkg::QW+1];
  logic              div_valid [m3i_pkg::QW+1];
  logic              div_ready [m3i_pkg::QW+1];
  logic [8:0][m3i_pkg::W-1:0] inv;
  logic [m3i_pkg::W-1:0]      det_value;
  logic              singular, overflow;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        mat[i][j] = in_tdata[(i*3+j)*m3i_pkg::W +: m3i_pkg::W];
      end
    end
  end

  m3i_cofactor u_cofactor (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .mat       (mat),
    .out_valid (cof_valid),
    .out_ready (cof_ready),
    .cof_bus   (cof_bus)
  );

  m3i_det u_det (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cof_valid),
    .in_ready  (cof_ready),
    .cof_bus   (cof_bus),
    .out_valid (div_valid[0]),
    .out_ready (div_ready[0]),
    .div_out   (div_bus[0])
  );

  for (genvar k = 0; k < m3i_pkg::QW; k++) begin : g_div
    m3i_div_step u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (div_valid[k]),
      .in_ready  (div_ready[k]),
      .div_in    (div_bus[k]),
      .out_valid (div_valid[k+1]),
      .out_ready (div_ready[k+1]),
      .div_out   (div_bus[k+1])
    );
  end

  m3i_output u_output (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (div_valid[m3i_pkg::QW]),
    .in_ready  (div_ready[m3i_pkg::QW]),
    .div_in    (div_bus[m3i_pkg::QW]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .inv       (inv),
    .det_value (det_value),
    .singular  (singular),
    .overflow  (overflow)
  );

  assign out_tdata = m3i_pkg::out_data_t'({det_value, inv});
  assign out_tuser = {overflow, singular};

  // With nothing waiting at the output every stage can advance, so the input
  // must be ready.
  `M3I_ASSERT_NOW(a_ready_when_empty, !out_tvalid, in_tready, "input stalled with empty output")
  // A singular result carries all-zero inverse entries.
  `M3I_ASSERT_NOW(a_singular_zero_inv, out_tvalid && out_tuser[0],
    out_tdata[9*m3i_pkg::W-1:0] == '0, "singular result with nonzero inverse")
  // A singular result has a zero determinant and no overflow.
  `M3I_ASSERT_NOW(a_singular_flags, out_tvalid && out_tuser[0],
    !out_tuser[1] && out_tdata[10*m3i_pkg::W-1:9*m3i_pkg::W] == '0,
    "singular result with overflow or nonzero determinant")

endmodule
`default_nettype wire

>>> src/m3i_cofactor.sv
`default_nettype none
// Two stages: the eighteen entry products, then the nine cofactors.
module m3i_cofactor (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire m3i_pkg::mat_t     mat,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output m3i_pkg::cof_bus_t      cof_bus
);

  m3i_pkg::prod_t [2:0][2:0][1:0] prod_r, prod_nxt;
  m3i_pkg::word_t [2:0]           row0_r;
  m3i_pkg::cof_bus_t              cof_r, cof_nxt;
  logic                           v1_r, v2_r;
  logic                           rdy1, rdy2;

  assign rdy2     = !v2_r || out_ready;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod_nxt[i][j][0] = m3i_pkg::prod_t'($signed(mat[(i+1)%3][(j+1)%3]))
                          * m3i_pkg::prod_t'($signed(mat[(i+2)%3][(j+2)%3]));
        prod_nxt[i][j][1] = m3i_pkg::prod_t'($signed(mat[(i+1)%3][(j+2)%3]))
                          * m3i_pkg::prod_t'($signed(mat[(i+2)%3][(j+1)%3]));
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        cof_nxt.cof[i][j] = m3i_pkg::cof_t'(prod_r[i][j][0])
                          - m3i_pkg::cof_t'(prod_r[i][j][1]);
      end
    end
    cof_nxt.row0 = row0_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      prod_r <= prod_nxt;
      row0_r <= mat[0];
    end
    if (rdy2) begin
      cof_r <= cof_nxt;
    end
  end

  assign out_valid = v2_r;
  assign cof_bus   = cof_r;

endmodule
`default_nettype wire

>>> src/m3i_det.sv
`default_nettype none
// Four stages: split partial products, terms, determinant sum, divider setup.
module m3i_det (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire m3i_pkg::cof_bus_t cof_bus,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output m3i_pkg::div_t          div_out
);

  m3i_pkg::pp_t [2:0]   lo_r, hi_r, lo_nxt, hi_nxt;
  m3i_pkg::det_t [2:0]  term_r, term_nxt;
  m3i_pkg::det_t        det_r, det_nxt;
  m3i_pkg::cof_bus_t    c1_r, c2_r, c3_r;
  m3i_pkg::div_t        div_r, div_nxt;
  m3i_pkg::dmag_t       dmag, dshr;
  m3i_pkg::cmag_t [8:0] cmag;
  logic                 dneg;
  logic [3:0]           v_r;
  logic [3:0]           rdy;

  assign rdy[3]   = !v_r[3] || out_ready;
  assign rdy[2]   = !v_r[2] || rdy[3];
  assign rdy[1]   = !v_r[1] || rdy[2];
  assign rdy[0]   = !v_r[0] || rdy[1];
  assign in_ready = rdy[0];

  // The cofactor is split into an unsigned low word and a signed high part
  // so that each multiplier stays about one word wide.
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      lo_nxt[j] = m3i_pkg::pp_t'($signed(cof_bus.row0[j]))
                * m3i_pkg::pp_t'($signed({1'b0, cof_bus.cof[0][j][m3i_pkg::W-1:0]}));
      hi_nxt[j] = m3i_pkg::pp_t'($signed(cof_bus.row0[j]))
                * m3i_pkg::pp_t'($signed(cof_bus.cof[0][j][m3i_pkg::CW-1:m3i_pkg::W]));
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      term_nxt[j] = (m3i_pkg::det_t'(hi_r[j]) <<< m3i_pkg::W) + m3i_pkg::det_t'(lo_r[j]);
    end
  end

  assign det_nxt = term_r[0] + term_r[1] + term_r[2];

  always_comb begin
    dneg = det_r[m3i_pkg::DW-1];
    dmag = dneg ? m3i_pkg::dmag_t'(~det_r + 1'b1) : m3i_pkg::dmag_t'(det_r);
    dshr = dmag >> (2 * m3i_pkg::F);
    div_nxt.zero = (det_r == '0);
    div_nxt.ds   = m3i_pkg::ds_t'(dmag) << m3i_pkg::W;
    div_nxt.det_ovf = 1'b0;
    if (!dneg && dshr > m3i_pkg::dmag_t'(m3i_pkg::WMAX)) begin
      div_nxt.det_value = m3i_pkg::WMAX;
      div_nxt.det_ovf   = 1'b1;
    end else if (dneg && dshr > m3i_pkg::dmag_t'(m3i_pkg::WMIN)) begin
      div_nxt.det_value = m3i_pkg::WMIN;
      div_nxt.det_ovf   = 1'b1;
    end else if (dneg) begin
      div_nxt.det_value = m3i_pkg::word_t'(~dshr + 1'b1);
    end else begin
      div_nxt.det_value = m3i_pkg::word_t'(dshr);
    end
    // Inverse entry (i, j) divides the transposed cofactor (j, i).
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        cmag[i*3+j] = c3_r.cof[j][i][m3i_pkg::CW-1]
                    ? m3i_pkg::cmag_t'(~c3_r.cof[j][i] + 1'b1)
                    : m3i_pkg::cmag_t'(c3_r.cof[j][i]);
        div_nxt.lane[i*3+j].r   = m3i_pkg::num_t'(cmag[i*3+j]) << (2 * m3i_pkg::F);
        div_nxt.lane[i*3+j].q   = '0;
        div_nxt.lane[i*3+j].neg = c3_r.cof[j][i][m3i_pkg::CW-1] ^ dneg;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= in_valid;
      end
      if (rdy[1]) begin
        v_r[1] <= v_r[0];
      end
      if (rdy[2]) begin
        v_r[2] <= v_r[1];
      end
      if (rdy[3]) begin
        v_r[3] <= v_r[2];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      lo_r <= lo_nxt;
      hi_r <= hi_nxt;
      c1_r <= cof_bus;
    end
    if (rdy[1]) begin
      term_r <= term_nxt;
      c2_r   <= c1_r;
    end
    if (rdy[2]) begin
      det_r <= det_nxt;
      c3_r  <= c2_r;
    end
    if (rdy[3]) begin
      div_r <= div_nxt;
    end
  end

  assign out_valid = v_r[3];
  assign div_out   = div_r;

endmodule
`default_nettype wire

>>> src/m3i_div_step.sv
`default_nettype none
// One restoring division step for all nine lanes against a shared divisor.
module m3i_div_step (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire m3i_pkg::div_t div_in,
  output logic               out_valid,
  input  wire logic          out_ready,
  output m3i_pkg::div_t      div_out
);

  m3i_pkg::div_t div_r, div_nxt;
  m3i_pkg::xw_t  dsx;
  m3i_pkg::xw_t  rx [9];
  logic [8:0]    ge;
  logic          v_r;

  assign in_ready = !v_r || out_ready;

  always_comb begin
    div_nxt    = div_in;
    dsx        = m3i_pkg::xw_t'(div_in.ds);
    div_nxt.ds = div_in.ds >> 1;
    for (int l = 0; l < 9; l++) begin
      rx[l] = m3i_pkg::xw_t'(div_in.lane[l].r);
      ge[l] = (rx[l] >= dsx);
      if (ge[l]) begin
        div_nxt.lane[l].r = m3i_pkg::num_t'(rx[l] - dsx);
      end
      div_nxt.lane[l].q = {div_in.lane[l].q[m3i_pkg::QW-2:0], ge[l]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      div_r <= div_nxt;
    end
  end

  assign out_valid = v_r;
  assign div_out   = div_r;

endmodule
`default_nettype wire

>>> src/m3i_output.sv
`default_nettype none
// Sign, saturation and singular handling, held in the output register.
module m3i_output (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire m3i_pkg::div_t        div_in,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [8:0][m3i_pkg::W-1:0] inv,
  output logic [m3i_pkg::W-1:0]     det_value,
  output logic                      singular,
  output logic                      overflow
);

  logic [8:0][m3i_pkg::W-1:0] inv_r, inv_nxt;
  logic [m3i_pkg::W-1:0]      det_r, det_nxt;
  logic                       sing_r, ovf_r, ovf_nxt;
  logic [8:0]                 lane_ovf;
  logic                       v_r;

  assign in_ready = !v_r || out_ready;

  always_comb begin
    for (int l = 0; l < 9; l++) begin
      lane_ovf[l] = 1'b0;
      if (!div_in.lane[l].neg && div_in.lane[l].q > m3i_pkg::quo_t'(m3i_pkg::WMAX)) begin
        inv_nxt[l]  = m3i_pkg::WMAX;
        lane_ovf[l] = 1'b1;
      end else if (div_in.lane[l].neg
                   && div_in.lane[l].q > m3i_pkg::quo_t'(m3i_pkg::WMIN)) begin
        inv_nxt[l]  = m3i_pkg::WMIN;
        lane_ovf[l] = 1'b1;
      end else if (div_in.lane[l].neg) begin
        inv_nxt[l] = m3i_pkg::word_t'(~div_in.lane[l].q + 1'b1);
      end else begin
        inv_nxt[l] = m3i_pkg::word_t'(div_in.lane[l].q);
      end
    end
    det_nxt = div_in.det_value;
    ovf_nxt = (|lane_ovf) | div_in.det_ovf;
    if (div_in.zero) begin
      inv_nxt = '0;
      det_nxt = '0;
      ovf_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      inv_r  <= inv_nxt;
      det_r  <= det_nxt;
      sing_r <= div_in.zero;
      ovf_r  <= ovf_nxt;
    end
  end

  assign out_valid = v_r;
  assign inv       = inv_r;
  assign det_value = det_r;
  assign singular  = sing_r;
  assign overflow  = ovf_r;

endmodule
`default_nettype wire
